// ===== hw/rtl/rc5_pkg.sv =====
// Shared types, constants and helper functions for the RC5-32 block cipher.
// No dependencies; rc5_ctrl, rc5_dp, rc5_block_cipher and rc5_checker import this package.
package rc5_pkg;

  localparam int unsigned ROUNDS_DEFAULT        = 16;
  localparam int unsigned MAX_KEY_WORDS_DEFAULT = 64;

  localparam logic [31:0] MAGIC_P = 32'hB7E15163;
  localparam logic [31:0] MAGIC_Q = 32'h9E3779B9;

  // fixed rotate used when mixing the round-key table
  localparam logic [4:0] MIX_ROT = 5'd3;

  typedef enum logic [1:0] {
    CMD_KEY = 2'd0,
    CMD_ENC = 2'd1,
    CMD_DEC = 2'd2,
    CMD_NOP = 2'd3
  } cmd_e;

  // controller -> datapath commands
  typedef struct packed {
    logic       blk_load;   // latch input block words
    logic       blk_step;   // one half-round with the round key on the read port
    logic       decrypt;
    logic       step_k0;    // whitening of word a
    logic       step_k1;    // whitening of word b
    logic       step_odd;   // half-round updates word b
    logic       key_store;  // merge key byte into the partial word
    logic       key_flush;  // write merged word to key-word RAM
    logic [1:0] byte_sel;
    logic       seed_init;
    logic       seed_wr;
    logic       mix_a;
    logic       mix_b;
    logic       rk_rd;
    logic       kw_rd;
    logic       out_load;
    logic       out_nokey;
  } dp_ctrl_t;

  function automatic logic [31:0] rotl32(logic [31:0] x, logic [4:0] n);
    logic [63:0] t;
    t = {x, x} << n;
    return t[63:32];
  endfunction

  function automatic logic [31:0] rotr32(logic [31:0] x, logic [4:0] n);
    logic [63:0] t;
    t = {x, x} >> n;
    return t[31:0];
  endfunction

endpackage

// ===== hw/rtl/rc5_if.sv =====
// Valid/ready channel interfaces for the RC5 cipher: request and result.
// No dependencies.
interface rc5_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  key_byte;
  logic        key_last;
  logic [31:0] word_a;
  logic [31:0] word_b;

  modport source (output valid, command, key_byte, key_last, word_a, word_b, input ready);
  modport sink   (input valid, command, key_byte, key_last, word_a, word_b, output ready);
endinterface

interface rc5_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_a;
  logic [31:0] out_b;
  logic        status;

  modport source (output valid, out_a, out_b, status, input ready);
  modport sink   (input valid, out_a, out_b, status, output ready);
endinterface

// ===== hw/rtl/rc5_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rc5_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 34,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/rc5_ctrl.sv =====
// Controller FSM for the RC5 cipher: key loading, key expansion sequencing,
// block rounds and result hand-off. Depends on rc5_pkg.
module rc5_ctrl
  import rc5_pkg::*;
#(
  parameter int unsigned ROUNDS        = ROUNDS_DEFAULT,
  parameter int unsigned MAX_KEY_WORDS = MAX_KEY_WORDS_DEFAULT,
  localparam int unsigned TableSize    = 2 * ROUNDS + 2,
  localparam int unsigned IdxW         = $clog2(TableSize),
  localparam int unsigned KwAw         = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [1:0]      in_command_i,
  input  logic            in_key_last_i,
  output logic            in_ready_o,
  input  logic            out_ready_i,
  output logic            out_valid_o,
  output dp_ctrl_t        ctrl_o,
  output logic [IdxW-1:0] rk_addr_o,
  output logic [KwAw-1:0] kw_addr_o
);

  localparam int unsigned KwCw     = $clog2(MAX_KEY_WORDS + 1);
  localparam int unsigned KwJw     = KwCw + 1;
  localparam int unsigned MaxBytes = 4 * MAX_KEY_WORDS;
  localparam int unsigned BcW      = $clog2(MaxBytes + 1);
  localparam int unsigned BcxW     = BcW + 1;
  localparam int unsigned MixMax   = (TableSize > MAX_KEY_WORDS) ? TableSize : MAX_KEY_WORDS;
  localparam int unsigned MixW     = $clog2(3 * MixMax + 1);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(TableSize - 1);

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SEED    = 7'b0000010,
    ST_MIX_RD  = 7'b0000100,
    ST_MIX_A   = 7'b0001000,
    ST_MIX_B   = 7'b0010000,
    ST_BLK_RUN = 7'b0100000,
    ST_FINISH  = 7'b1000000
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [KwAw-1:0] kw_idx_q, kw_idx_d;
  logic [KwCw-1:0] kw_lim_q, kw_lim_d;
  logic [MixW-1:0] mix_left_q, mix_left_d;
  logic [BcW-1:0]  byte_cnt_q, byte_cnt_d;
  logic            key_ready_q, key_ready_d;
  logic            decrypt_q, decrypt_d;
  logic            nokey_q, nokey_d;
  logic            out_valid_q, out_valid_d;

  logic            accept;
  logic            byte_keep;
  logic [BcW-1:0]  cnt_after;
  logic [BcxW-1:0] words_wide;
  logic [KwCw-1:0] key_words;
  logic [MixW-1:0] mix_span;
  logic [KwJw-1:0] kw_next;
  logic            kw_wrap;
  logic            blk_last;
  logic [IdxW-1:0] blk_next;
  logic [IdxW-1:0] blk_first;
  logic            is_dec;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign accept      = in_valid_i && in_ready_o;

  // key word count of the key being loaded: ceil(bytes / 4), at least one
  assign byte_keep  = byte_cnt_q < BcW'(MaxBytes);
  assign cnt_after  = byte_keep ? (byte_cnt_q + BcW'(1)) : byte_cnt_q;
  assign words_wide = (BcxW'(cnt_after) + BcxW'(3)) >> 2;
  assign key_words  = (KwCw'(words_wide) == '0) ? KwCw'(1) : KwCw'(words_wide);
  assign mix_span   = (MixW'(key_words) > MixW'(TableSize)) ? MixW'(key_words)
                                                            : MixW'(TableSize);

  assign kw_next = KwJw'(kw_idx_q) + KwJw'(1);
  assign kw_wrap = kw_next >= KwJw'(kw_lim_q);

  assign is_dec    = (in_command_i == CMD_DEC);
  assign blk_first = is_dec ? IdxLast : '0;
  assign blk_last  = decrypt_q ? (idx_q == '0) : (idx_q == IdxLast);
  assign blk_next  = decrypt_q ? (idx_q - IdxW'(1)) : (idx_q + IdxW'(1));

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    kw_idx_d    = kw_idx_q;
    kw_lim_d    = kw_lim_q;
    mix_left_d  = mix_left_q;
    byte_cnt_d  = byte_cnt_q;
    key_ready_d = key_ready_q;
    decrypt_d   = decrypt_q;
    nokey_d     = nokey_q;
    out_valid_d = out_valid_q;
    ctrl_o      = '0;
    rk_addr_o   = idx_q;
    kw_addr_o   = kw_idx_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_command_i)
            CMD_KEY: begin
              ctrl_o.key_store = byte_keep;
              ctrl_o.byte_sel  = byte_cnt_q[1:0];
              ctrl_o.key_flush = byte_keep && ((byte_cnt_q[1:0] == 2'd3) || in_key_last_i);
              kw_addr_o        = KwAw'(byte_cnt_q >> 2);
              byte_cnt_d       = cnt_after;
              if (in_key_last_i) begin
                ctrl_o.seed_init = 1'b1;
                kw_lim_d         = key_words;
                mix_left_d       = mix_span + mix_span + mix_span;
                idx_d            = '0;
                state_d          = ST_SEED;
              end
            end
            CMD_ENC, CMD_DEC: begin
              decrypt_d = is_dec;
              if (key_ready_q) begin
                ctrl_o.blk_load = 1'b1;
                ctrl_o.rk_rd    = 1'b1;
                rk_addr_o       = blk_first;
                idx_d           = blk_first;
                nokey_d         = 1'b0;
                state_d         = ST_BLK_RUN;
              end else begin
                nokey_d = 1'b1;
                state_d = ST_FINISH;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SEED: begin
        ctrl_o.seed_wr = 1'b1;
        if (idx_q == IdxLast) begin
          idx_d    = '0;
          kw_idx_d = '0;
          state_d  = ST_MIX_RD;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_MIX_RD: begin
        ctrl_o.rk_rd = 1'b1;
        ctrl_o.kw_rd = 1'b1;
        state_d      = ST_MIX_A;
      end
      ST_MIX_A: begin
        ctrl_o.mix_a = 1'b1;
        state_d      = ST_MIX_B;
      end
      ST_MIX_B: begin
        ctrl_o.mix_b = 1'b1;
        idx_d        = (idx_q == IdxLast) ? '0 : (idx_q + IdxW'(1));
        kw_idx_d     = kw_wrap ? '0 : KwAw'(kw_next);
        if (mix_left_q == MixW'(1)) begin
          key_ready_d = 1'b1;
          byte_cnt_d  = '0;
          state_d     = ST_IDLE;
        end else begin
          mix_left_d = mix_left_q - MixW'(1);
          state_d    = ST_MIX_RD;
        end
      end
      ST_BLK_RUN: begin
        ctrl_o.blk_step = 1'b1;
        ctrl_o.decrypt  = decrypt_q;
        ctrl_o.step_k0  = (idx_q == '0);
        ctrl_o.step_k1  = (idx_q == IdxW'(1));
        ctrl_o.step_odd = idx_q[0];
        if (blk_last) begin
          state_d = ST_FINISH;
        end else begin
          ctrl_o.rk_rd = 1'b1;
          rk_addr_o    = blk_next;
          idx_d        = blk_next;
        end
      end
      ST_FINISH: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          ctrl_o.out_load  = 1'b1;
          ctrl_o.out_nokey = nokey_q;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      kw_idx_q    <= '0;
      kw_lim_q    <= '0;
      mix_left_q  <= '0;
      byte_cnt_q  <= '0;
      key_ready_q <= 1'b0;
      decrypt_q   <= 1'b0;
      nokey_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      kw_idx_q    <= kw_idx_d;
      kw_lim_q    <= kw_lim_d;
      mix_left_q  <= mix_left_d;
      byte_cnt_q  <= byte_cnt_d;
      key_ready_q <= key_ready_d;
      decrypt_q   <= decrypt_d;
      nokey_q     <= nokey_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

// ===== hw/rtl/rc5_dp.sv =====
// Datapath for the RC5 cipher: block word registers, half-round unit,
// key-schedule mixer, round-key and key-word RAMs, result register.
// Depends on rc5_pkg and rc5_ram.
module rc5_dp
  import rc5_pkg::*;
#(
  parameter int unsigned ROUNDS        = ROUNDS_DEFAULT,
  parameter int unsigned MAX_KEY_WORDS = MAX_KEY_WORDS_DEFAULT,
  localparam int unsigned TableSize    = 2 * ROUNDS + 2,
  localparam int unsigned IdxW         = $clog2(TableSize),
  localparam int unsigned KwAw         = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dp_ctrl_t        ctrl_i,
  input  logic [IdxW-1:0] rk_addr_i,
  input  logic [KwAw-1:0] kw_addr_i,
  input  logic [7:0]      key_byte_i,
  input  logic [31:0]     word_a_i,
  input  logic [31:0]     word_b_i,
  output logic [31:0]     out_a_o,
  output logic [31:0]     out_b_o,
  output logic            status_o
);

  logic [31:0] a_q, b_q, ab_q, seed_q, part_q;
  logic [31:0] out_a_q, out_b_q;
  logic        status_q;

  logic [31:0] rk_rdata, kw_rdata;
  logic [31:0] rk_wdata, kw_wdata;
  logic [31:0] merged;
  logic [31:0] a_mix, b_mix;
  logic [31:0] enc_a, enc_b, dec_a, dec_b;
  logic [31:0] step_a, step_b;

  assign merged = part_q | ({24'd0, key_byte_i} << {ctrl_i.byte_sel, 3'b000});

  assign a_mix = rotl32(rk_rdata + a_q + b_q, MIX_ROT);
  assign b_mix = rotl32(kw_rdata + ab_q, ab_q[4:0]);

  assign enc_a = rotl32(a_q ^ b_q, b_q[4:0]) + rk_rdata;
  assign enc_b = rotl32(b_q ^ a_q, a_q[4:0]) + rk_rdata;
  assign dec_a = rotr32(a_q - rk_rdata, b_q[4:0]) ^ b_q;
  assign dec_b = rotr32(b_q - rk_rdata, a_q[4:0]) ^ a_q;

  always_comb begin
    step_a = a_q;
    step_b = b_q;
    if (ctrl_i.step_k0) begin
      step_a = ctrl_i.decrypt ? (a_q - rk_rdata) : (a_q + rk_rdata);
    end else if (ctrl_i.step_k1) begin
      step_b = ctrl_i.decrypt ? (b_q - rk_rdata) : (b_q + rk_rdata);
    end else if (ctrl_i.step_odd) begin
      step_b = ctrl_i.decrypt ? dec_b : enc_b;
    end else begin
      step_a = ctrl_i.decrypt ? dec_a : enc_a;
    end
  end

  assign rk_wdata = ctrl_i.seed_wr ? seed_q : a_mix;
  assign kw_wdata = ctrl_i.mix_b ? b_mix : merged;

  rc5_ram #(
    .WIDTH (32),
    .DEPTH (TableSize)
  ) u_rk_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.seed_wr | ctrl_i.mix_a),
    .waddr_i (rk_addr_i),
    .wdata_i (rk_wdata),
    .re_i    (ctrl_i.rk_rd),
    .raddr_i (rk_addr_i),
    .rdata_o (rk_rdata)
  );

  rc5_ram #(
    .WIDTH (32),
    .DEPTH (MAX_KEY_WORDS)
  ) u_kw_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.key_flush | ctrl_i.mix_b),
    .waddr_i (kw_addr_i),
    .wdata_i (kw_wdata),
    .re_i    (ctrl_i.kw_rd),
    .raddr_i (kw_addr_i),
    .rdata_o (kw_rdata)
  );

  always_ff @(posedge clk_i) begin
    if (ctrl_i.blk_load) begin
      a_q <= word_a_i;
      b_q <= word_b_i;
    end else if (ctrl_i.seed_init) begin
      a_q <= '0;
      b_q <= '0;
    end else if (ctrl_i.blk_step) begin
      a_q <= step_a;
      b_q <= step_b;
    end else if (ctrl_i.mix_a) begin
      a_q <= a_mix;
    end else if (ctrl_i.mix_b) begin
      b_q <= b_mix;
    end

    // a + b for the key-word update, taken once a is known
    if (ctrl_i.mix_a) begin
      ab_q <= a_mix + b_q;
    end

    if (ctrl_i.seed_init) begin
      seed_q <= MAGIC_P;
    end else if (ctrl_i.seed_wr) begin
      seed_q <= seed_q + MAGIC_Q;
    end

    if (ctrl_i.out_load) begin
      out_a_q  <= ctrl_i.out_nokey ? 32'd0 : a_q;
      out_b_q  <= ctrl_i.out_nokey ? 32'd0 : b_q;
      status_q <= ctrl_i.out_nokey;
    end
  end

  // partial key word starts empty so the first key merges into zeros
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      part_q <= '0;
    end else if (ctrl_i.seed_init) begin
      part_q <= '0;
    end else if (ctrl_i.key_store) begin
      part_q <= ctrl_i.key_flush ? 32'd0 : merged;
    end
  end

  assign out_a_o  = out_a_q;
  assign out_b_o  = out_b_q;
  assign status_o = status_q;

endmodule

// ===== hw/rtl/rc5_block_cipher.sv =====
// RC5-32 block cipher top level: controller plus datapath, valid/ready channels.
// Depends on rc5_pkg, rc5_if, rc5_ctrl, rc5_dp (and rc5_ram below it).
// Block: one half-round per cycle off the round-key RAM; no new request is taken until the
//   result is loaded into the output register, which waits while an earlier result is pending.
// No key: the request goes straight to the finish state and yields zero words with status set.
// Key bytes: one per cycle. Last byte: expansion seeds the round-key table, then mixes it with the key words.
// Reset clears the FSM, byte count, partial key word and key-loaded flag; RAMs are left as is.
module rc5_block_cipher
  import rc5_pkg::*;
#(
  parameter int unsigned ROUNDS        = ROUNDS_DEFAULT,
  parameter int unsigned MAX_KEY_WORDS = MAX_KEY_WORDS_DEFAULT
) (
  input logic        clk_i,
  input logic        rst_ni,
  rc5_in_if.sink     in_i,
  rc5_out_if.source  out_o
);

  localparam int unsigned TableSize = 2 * ROUNDS + 2;
  localparam int unsigned IdxW      = $clog2(TableSize);
  localparam int unsigned KwAw      = (MAX_KEY_WORDS > 1) ? $clog2(MAX_KEY_WORDS) : 1;

  dp_ctrl_t        dp_ctrl;
  logic [IdxW-1:0] rk_addr;
  logic [KwAw-1:0] kw_addr;
  logic            in_ready;
  logic            out_valid;
  logic [31:0]     out_a;
  logic [31:0]     out_b;
  logic            status;

  rc5_ctrl #(
    .ROUNDS        (ROUNDS),
    .MAX_KEY_WORDS (MAX_KEY_WORDS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_i.valid),
    .in_command_i  (in_i.command),
    .in_key_last_i (in_i.key_last),
    .in_ready_o    (in_ready),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_valid),
    .ctrl_o        (dp_ctrl),
    .rk_addr_o     (rk_addr),
    .kw_addr_o     (kw_addr)
  );

  rc5_dp #(
    .ROUNDS        (ROUNDS),
    .MAX_KEY_WORDS (MAX_KEY_WORDS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (dp_ctrl),
    .rk_addr_i  (rk_addr),
    .kw_addr_i  (kw_addr),
    .key_byte_i (in_i.key_byte),
    .word_a_i   (in_i.word_a),
    .word_b_i   (in_i.word_b),
    .out_a_o    (out_a),
    .out_b_o    (out_b),
    .status_o   (status)
  );

  assign in_i.ready   = in_ready;
  assign out_o.valid  = out_valid;
  assign out_o.out_a  = out_a;
  assign out_o.out_b  = out_b;
  assign out_o.status = status;

endmodule

// ===== hw/rtl/rc5_checker.sv =====
// Port-level assertions for rc5_block_cipher, attached by the bind below.
// Depends on rc5_pkg and rc5_block_cipher.
module rc5_checker
  import rc5_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic [1:0]  in_command_i,
  input logic        in_key_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_a_i,
  input logic [31:0] out_b_i,
  input logic        status_i
);

  logic in_xact;
  assign in_xact = in_valid_i && in_ready_i;

  // a pending result stays put until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable({out_a_i, out_b_i, status_i}))
    else $error("result changed or dropped while stalled");

  // a block transaction occupies the cipher on the next cycle
  a_blk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xact && (in_command_i == CMD_ENC || in_command_i == CMD_DEC) |=> !in_ready_i)
    else $error("ready high right after a block transaction");

  // a plain key byte leaves the cipher ready on the next cycle
  a_key_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xact && (in_command_i == CMD_KEY) && !in_key_last_i |=> in_ready_i)
    else $error("ready dropped after a non-final key byte");

  // missing-key results carry zero words
  a_nokey_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> out_a_i == 32'd0 && out_b_i == 32'd0)
    else $error("missing-key result with nonzero words");

endmodule

bind rc5_block_cipher rc5_checker u_rc5_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .in_command_i  (in_i.command),
  .in_key_last_i (in_i.key_last),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_a_i       (out_o.out_a),
  .out_b_i       (out_o.out_b),
  .status_i      (out_o.status)
);
